@@ design/q32nr_pkg.sv @@
// Shared constants and helper functions for the Q32.32 Newton-Raphson divider.
package q32nr_pkg;

  // Refinement steps x = x*(2 - b*x)
  localparam int REFINE_STEPS = 5;

  // Pipeline depth: abs, guess, 4 per step, 2 for the final multiply, output.
  localparam int NUM_STAGES = 5 + 4 * REFINE_STEPS;

  localparam logic [63:0] Q_TWO   = 64'h0000_0002_0000_0000;
  localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_NEG = 64'h8000_0001_0000_0000;

  // Index of the highest set bit (0 when none is set).
  function automatic logic [4:0] msb_index(input logic [31:0] val);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (val[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  // First reciprocal guess from the divisor's leading one.
  function automatic logic [63:0] first_guess(input logic [63:0] b);
    logic [31:0] bhi;
    logic [31:0] blo;
    logic [4:0]  zc;
    logic [63:0] g;
    bhi = b[63:32];
    blo = b[31:0];
    if (bhi != 32'd0 && !bhi[31]) begin
      g = 64'h0000_0000_8000_0000 >> msb_index(bhi);
    end else begin
      // leading zeros of the fraction; an empty fraction counts as none
      zc = (blo == 32'd0) ? 5'd0 : 5'd31 - msb_index(blo);
      if (zc >= 5'd30) g = 64'h4000_0000_0000_0000;
      else             g = 64'h0000_0002_0000_0000 << zc;
    end
    return g;
  endfunction

endpackage

@@ design/q32nr_ifs.sv @@
// Valid/ready channel interfaces for the divider operands and quotient.
interface q32nr_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] dividend;
  logic signed [63:0] divisor;
  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface q32nr_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] quotient;
  modport source (output valid, output quotient, input ready);
  modport sink   (input valid, input quotient, output ready);
endinterface

@@ design/q32nr_qmul.sv @@
// Q32.32 multiplier: registered 32x32 partial products, then the combine.
module q32nr_qmul
  import q32nr_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll;
  logic [63:0] lh;
  logic [63:0] hl;
  logic [63:0] hh;
  logic [31:0] corr;
  logic [33:0] mid;
  logic [31:0] hi;

  // Partial products and the signed correction (only its low word matters)
  always_ff @(posedge clk) begin
    if (en) begin
      ll   <= 64'(a[31:0])  * 64'(b[31:0]);
      lh   <= 64'(a[31:0])  * 64'(b[63:32]);
      hl   <= 64'(a[63:32]) * 64'(b[31:0]);
      hh   <= 64'(a[63:32]) * 64'(b[63:32]);
      corr <= (a[63] ? b[31:0] : 32'd0) + (b[63] ? a[31:0] : 32'd0);
    end
  end

  // Bits 32..95 of the product
  always_comb begin
    mid = 34'(ll[63:32]) + 34'(lh[31:0]) + 34'(hl[31:0]);
    hi  = hh[31:0] + lh[63:32] + hl[63:32] + 32'(mid[33:32]) - corr;
    p   = {hi, mid[31:0]};
  end

endmodule

@@ design/q32_32_newton_raphson_divider_core.sv @@
// Top level of the pipelined Q32.32 Newton-Raphson divider.
// Signed Q32.32 divider. One operand pair is taken per cycle while the
// output side does not stall. The pipeline depth comes from the eleven
// 64-bit multiplies. Each takes two stages: the 32x32 partial products,
// then the combine. A stall on the output side fills the empty stages one
// at a time. Input is still taken while a quotient waits, until the
// pipeline is full. A zero divisor returns a saturated value, SAT_POS or
// SAT_NEG, selected by the operand signs. All other overflow wraps at 64
// bits.
module q32_32_newton_raphson_divider_core
  import q32nr_pkg::*;
(
  input logic         clk,
  input logic         rst,
  q32nr_in_if.sink    operands,
  q32nr_out_if.source result
);

  localparam int N  = NUM_STAGES;
  localparam int FS = 2 + 4 * REFINE_STEPS;

  logic        v  [N];
  logic        en [N];
  logic [63:0] ca [N-1];
  logic [63:0] cb [N-1];
  logic [63:0] cx [N-1];
  logic [63:0] ct [N-1];
  logic        cneg  [N-1];
  logic        czero [N-1];
  logic [63:0] xin [N-1];
  logic [63:0] tin [N-1];
  logic [63:0] prod_bx [REFINE_STEPS];
  logic [63:0] prod_xt [REFINE_STEPS];
  logic [63:0] prod_f;
  logic [63:0] qo;
  logic [63:0] abs_a;
  logic [63:0] abs_b;

  // Per-stage enable: a stage moves when empty or when its successor moves
  always_comb begin
    en[N-1] = !v[N-1] || result.ready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign operands.ready  = en[0];
  assign result.valid    = v[N-1];
  assign result.quotient = qo;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) v[i] <= 1'b0;
    end else begin
      if (en[0]) v[0] <= operands.valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // Stage 0: magnitudes, sign and zero divisor
  assign abs_a = operands.dividend[63] ? 64'd0 - operands.dividend : operands.dividend;
  assign abs_b = operands.divisor[63]  ? 64'd0 - operands.divisor  : operands.divisor;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ca[0]    <= abs_a;
      cb[0]    <= abs_b;
      cx[0]    <= 64'd0;
      ct[0]    <= 64'd0;
      cneg[0]  <= operands.dividend[63] ^ operands.divisor[63];
      czero[0] <= (abs_b == 64'd0);
    end
  end

  // Next x and t per stage: pass through, unless a stage computes them
  always_comb begin
    xin[0] = 64'd0;
    tin[0] = 64'd0;
    for (int i = 1; i < N - 1; i++) begin
      xin[i] = cx[i-1];
      tin[i] = ct[i-1];
    end
    xin[1] = first_guess(cb[0]);
    for (int s = 0; s < REFINE_STEPS; s++) begin
      tin[2 + 4*s + 1] = Q_TWO - prod_bx[s];
      xin[2 + 4*s + 3] = prod_xt[s];
    end
    xin[FS + 1] = prod_f;
  end

  // Side-band registers of stages 1 .. N-2
  for (genvar gi = 1; gi < N - 1; gi++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en[gi]) begin
        ca[gi]    <= ca[gi-1];
        cb[gi]    <= cb[gi-1];
        cx[gi]    <= xin[gi];
        ct[gi]    <= tin[gi];
        cneg[gi]  <= cneg[gi-1];
        czero[gi] <= czero[gi-1];
      end
    end
  end

  // Refinement steps: b*x, then x*(2 - b*x)
  for (genvar gs = 0; gs < REFINE_STEPS; gs++) begin : g_step
    q32nr_qmul u_mul_bx (
      .clk (clk),
      .en  (en[2 + 4*gs]),
      .a   (cb[1 + 4*gs]),
      .b   (cx[1 + 4*gs]),
      .p   (prod_bx[gs])
    );
    q32nr_qmul u_mul_xt (
      .clk (clk),
      .en  (en[4 + 4*gs]),
      .a   (cx[3 + 4*gs]),
      .b   (ct[3 + 4*gs]),
      .p   (prod_xt[gs])
    );
  end

  // Dividend times reciprocal
  q32nr_qmul u_mul_f (
    .clk (clk),
    .en  (en[FS]),
    .a   (ca[FS-1]),
    .b   (cx[FS-1]),
    .p   (prod_f)
  );

  // Output stage: saturation or sign restore
  always_ff @(posedge clk) begin
    if (en[N-1]) begin
      if (czero[N-2])     qo <= cneg[N-2] ? SAT_NEG : SAT_POS;
      else if (cneg[N-2]) qo <= 64'd0 - cx[N-2];
      else                qo <= cx[N-2];
    end
  end

endmodule
